/* rtl/wmfc_pkg.sv */
// Package for the five-channel windowed mean unit.
// Holds widths, register indexes and the sequencer state type; no dependencies.
`timescale 1ns / 1ps
package wmfc_pkg;
    localparam int MaxWindow   = 64;
    localparam int SampleWidth = 32;
    localparam int AddrWidth   = $clog2(MaxWindow);
    localparam int FillWidth   = $clog2(MaxWindow + 1);
    localparam int WinWidth    = 7;
    localparam int NumChan     = 5;
    localparam int NumGroup    = 3;
    localparam int SumWidth    = SampleWidth + FillWidth;
    localparam int QuotWidth   = SumWidth;
    localparam int DivCntWidth = $clog2(QuotWidth + 1);

    localparam logic [1:0] RegWinVel = 2'd0;
    localparam logic [1:0] RegWinAcc = 2'd1;
    localparam logic [1:0] RegWinYaw = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_WRITE = 6'b000010,
        ST_SUM   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_NEXT  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    // Group index of each channel.
    function automatic logic [1:0] chan_group(input logic [2:0] ch);
        case (ch)
            3'd0, 3'd1: chan_group = 2'd0;
            3'd2, 3'd3: chan_group = 2'd1;
            default:    chan_group = 2'd2;
        endcase
    endfunction
endpackage

/* rtl/windowed_mean_five_channel_unit.sv */
// Top level of the five-channel windowed mean unit.
// Depends on wmfc_pkg; holds the history memory and the mean sequencer.
`timescale 1ns / 1ps
// One item is worked on at a time. A finished result moves into an output register, so the
// next item can be taken while that result waits. A new result waits in its last state until
// the output register is free. A channel with a window of 0 or 1 passes the sample through in
// the write state and then steps to the next channel. An averaged channel takes these steps:
// - the write of the new sample into the history memory;
// - one read per stored entry from the history memory (one read port, window up to 64),
//   then the collection of the last read data;
// - a restoring divider, after which the quotient is stored;
// - a step to the next channel.
// The history memory needs no clearing, because the mean only reads entries that were written.
module windowed_mean_five_channel_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vel_long[31:0], vel_lat[63:32], acc_long[95:64], acc_lat[127:96], yaw[159:128]
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // mean_vel_long, mean_vel_lat, mean_acc_long, mean_acc_lat, mean_yaw, low first
    output logic [159:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [6:0]   cfg_wdata
);
    localparam int AW = wmfc_pkg::AddrWidth;
    localparam int FW = wmfc_pkg::FillWidth;
    localparam int SW = wmfc_pkg::SampleWidth;
    localparam int UW = wmfc_pkg::SumWidth;
    localparam int QW = wmfc_pkg::QuotWidth;
    localparam int CW = wmfc_pkg::DivCntWidth;

    // History memory: channel in the upper address bits.
    logic [SW-1:0] mem [wmfc_pkg::NumChan*wmfc_pkg::MaxWindow];
    logic [SW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW+2:0] mem_waddr, mem_raddr;

    logic [wmfc_pkg::WinWidth-1:0] win_reg [wmfc_pkg::NumGroup];
    logic [FW-1:0] fill_reg [wmfc_pkg::NumGroup];
    logic [AW-1:0] head_reg [wmfc_pkg::NumGroup];

    wmfc_pkg::state_t state_reg;
    logic [2:0]     ch_reg;
    logic [159:0]   in_reg, out_reg, res_reg;
    logic           out_valid_reg;
    logic [FW-1:0]  cnt_reg, fcnt_reg;
    logic [AW-1:0]  idx_reg;
    logic           rd_pend_reg;
    logic [UW-1:0]  sum_reg;
    logic           neg_reg;
    logic [QW-1:0]  quo_reg;
    logic [FW:0]    rem_reg;
    logic [CW-1:0]  dcnt_reg;

    logic [1:0]    grp;
    logic [FW-1:0] win_sat, fill_new;
    logic          avg_en;
    logic [FW:0]   rem_shift;
    logic [QW-1:0] quo_signed;

    // Window of the current channel's group, saturated to the memory depth.
    always_comb begin
        grp = wmfc_pkg::chan_group(ch_reg);
        win_sat = (win_reg[grp] > wmfc_pkg::WinWidth'(wmfc_pkg::MaxWindow))
            ? FW'(wmfc_pkg::MaxWindow) : FW'(win_reg[grp]);
        avg_en = (win_reg[grp] > wmfc_pkg::WinWidth'(1));
        fill_new = (fill_reg[grp] + FW'(1) > win_sat) ? win_sat : fill_reg[grp] + FW'(1);
        rem_shift = {rem_reg[FW-1:0], quo_reg[QW-1]};
        quo_signed = neg_reg ? (~quo_reg + QW'(1)) : quo_reg;
    end

    assign s_tready = (state_reg == wmfc_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    // Memory port control.
    assign mem_we    = (state_reg == wmfc_pkg::ST_WRITE) && avg_en;
    assign mem_waddr = {ch_reg, head_reg[grp]};
    assign mem_raddr = {ch_reg, idx_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= in_reg[ch_reg*SW +: SW];
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < wmfc_pkg::NumGroup; g++) begin
                win_reg[g] <= wmfc_pkg::WinWidth'(1);
            end
        end else if (cfg_we) begin
            case (cfg_index)
                wmfc_pkg::RegWinVel: win_reg[0] <= cfg_wdata;
                wmfc_pkg::RegWinAcc: win_reg[1] <= cfg_wdata;
                wmfc_pkg::RegWinYaw: win_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer: per channel write, sum the newest entries, divide; windows of 0 or 1 pass through.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wmfc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
            rd_pend_reg   <= 1'b0;
            for (int g = 0; g < wmfc_pkg::NumGroup; g++) begin
                fill_reg[g] <= '0;
                head_reg[g] <= '0;
            end
        end else begin
            // The output register fills when it is empty or being emptied.
            if (state_reg == wmfc_pkg::ST_OUT && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                wmfc_pkg::ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        in_reg    <= s_tdata;
                        ch_reg    <= '0;
                        state_reg <= wmfc_pkg::ST_WRITE;
                    end
                end
                wmfc_pkg::ST_WRITE: begin
                    if (!avg_en) begin
                        out_reg[ch_reg*SW +: SW] <= in_reg[ch_reg*SW +: SW];
                        state_reg <= wmfc_pkg::ST_NEXT;
                    end else begin
                        // Sum walks back from the slot just written.
                        idx_reg     <= head_reg[grp];
                        cnt_reg     <= fill_new;
                        fcnt_reg    <= fill_new;
                        sum_reg     <= '0;
                        rd_pend_reg <= 1'b0;
                        state_reg   <= wmfc_pkg::ST_SUM;
                    end
                end
                wmfc_pkg::ST_SUM: begin
                    if (rd_pend_reg) begin
                        sum_reg <= sum_reg + UW'(signed'(rd_data_reg));
                    end
                    if (cnt_reg != '0) begin
                        idx_reg     <= idx_reg - AW'(1);
                        cnt_reg     <= cnt_reg - FW'(1);
                        rd_pend_reg <= 1'b1;
                    end else if (rd_pend_reg) begin
                        rd_pend_reg <= 1'b0;
                    end else begin
                        neg_reg   <= sum_reg[UW-1];
                        quo_reg   <= sum_reg[UW-1] ? (~sum_reg + UW'(1)) : sum_reg;
                        rem_reg   <= '0;
                        dcnt_reg  <= CW'(QW);
                        state_reg <= wmfc_pkg::ST_DIV;
                    end
                end
                wmfc_pkg::ST_DIV: begin
                    // Restoring divide of the magnitude, one quotient bit per cycle.
                    if (dcnt_reg != '0) begin
                        if (rem_shift >= {1'b0, fcnt_reg}) begin
                            rem_reg <= rem_shift - {1'b0, fcnt_reg};
                            quo_reg <= {quo_reg[QW-2:0], 1'b1};
                        end else begin
                            rem_reg <= rem_shift;
                            quo_reg <= {quo_reg[QW-2:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg - CW'(1);
                    end else begin
                        out_reg[ch_reg*SW +: SW] <= quo_signed[SW-1:0];
                        state_reg <= wmfc_pkg::ST_NEXT;
                    end
                end
                wmfc_pkg::ST_NEXT: begin
                    // Last channel of a group commits its fill and head.
                    if (avg_en && (ch_reg == 3'd1 || ch_reg == 3'd3 || ch_reg == 3'd4)) begin
                        fill_reg[grp] <= fill_new;
                        head_reg[grp] <= head_reg[grp] + AW'(1);
                    end
                    if (ch_reg == 3'(wmfc_pkg::NumChan - 1)) begin
                        state_reg <= wmfc_pkg::ST_OUT;
                    end else begin
                        ch_reg    <= ch_reg + 3'd1;
                        state_reg <= wmfc_pkg::ST_WRITE;
                    end
                end
                wmfc_pkg::ST_OUT: begin
                    // Hand the result over once the output register is free.
                    if (!out_valid_reg || m_tready) begin
                        res_reg   <= out_reg;
                        state_reg <= wmfc_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= wmfc_pkg::ST_IDLE;
            endcase
        end
    end

    // The fill counts of groups 0 and 2 never exceed the memory depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg[0] <= FW'(wmfc_pkg::MaxWindow) && fill_reg[2] <= FW'(wmfc_pkg::MaxWindow))
        else $error("fill count above depth");
    // A result is raised only after the output state.
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == wmfc_pkg::ST_OUT))
        else $error("result raised outside sequencer");
    // No new item while work is under way.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != wmfc_pkg::ST_IDLE) |-> !s_tready)
        else $error("accept while busy");
endmodule
